>>> rtl/vertex_normal_accumulate_core_macros.svh
// Assertion macros used by the checker file of the vertex normal block.
`ifndef VERTEX_NORMAL_ACCUMULATE_CORE_MACROS_SVH
`define VERTEX_NORMAL_ACCUMULATE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define VNACC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define VNACC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/vnacc_pkg.sv
// Shared types, codes and constants of the vertex normal block.
`timescale 1ns / 1ps

package vnacc_pkg;

  localparam int VERTICES_DEF    = 1024;
  localparam int COORD_WIDTH_DEF = 16;

  localparam int IDX_W   = 10;
  localparam int OUT_W   = 16;
  localparam int SUM_W   = 24;
  localparam int CNT_W   = 5;
  localparam int CFG_W   = 2;
  localparam int NORM_HI = 30;
  localparam int NORM_LO = 29;
  localparam int NM_W    = 30;
  localparam int SS_W    = 62;
  localparam int RT_W    = 31;
  localparam int Q_W     = 15;
  localparam int FRAC_W  = 14;
  localparam int DIV_N_W = 45;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 15;
  localparam int CROSS_LAST = 6;
  localparam int SQ_LAST    = 3;

  localparam int ONE_Q14 = 16384;
  localparam int SUM_MAX = 8388607;
  localparam int SUM_MIN = -8388608;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_TRI   = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic [CFG_W-1:0] CFG_FLIP_X = 2'd0;
  localparam logic [CFG_W-1:0] CFG_FLIP_Y = 2'd1;
  localparam logic [CFG_W-1:0] CFG_FLIP_Z = 2'd2;

  typedef enum logic [4:0] {
    ST_CLR,
    ST_IDLE,
    ST_RDA,
    ST_RDB,
    ST_RDC,
    ST_RDD,
    ST_CROSS,
    ST_SUMRD,
    ST_SUMLD,
    ST_NORM,
    ST_SQ,
    ST_SQRT,
    ST_DIVI,
    ST_DIV,
    ST_ACCRD,
    ST_ACCWR,
    ST_OUT
  } state_t;

endpackage

>>> rtl/vnacc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module vnacc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

>>> rtl/vertex_normal_accumulate_core.sv
// Top level of the vertex normal accumulator.
`timescale 1ns / 1ps

// Per-vertex normals of a triangle mesh. Op 1 writes a vertex position
// (signed Q8.8). Op 2 takes the cross product of a triangle's edges,
// scales it to a Q1.14 unit vector and adds it to the 24-bit saturating
// sums of its three corners; a degenerate triangle, or one with an index
// out of range, adds nothing. Op 3 returns the unit vector of one vertex's
// sum (zero for a zero sum or an index out of range), each axis negated
// when its flip register is set. Op 0 zeroes all sums. During a clear,
// and the sweep that follows reset, no item is accepted. One shared
// multiplier builds the cross product and the squares, a one-bit-per-cycle
// shifter normalizes, then the square root is taken and the three divides
// go through one compare-subtract unit. in_stall stays high while an item
// is in work; a finished read result waits for the output register, so a
// result beat stalled there holds the block until it is taken.
module vertex_normal_accumulate_core #(
  parameter int VERTICES    = vnacc_pkg::VERTICES_DEF,
  parameter int COORD_WIDTH = vnacc_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [vnacc_pkg::CFG_W-1:0]         cfg_index,
  input  logic                                cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_op,
  input  logic [vnacc_pkg::IDX_W-1:0]         in_vertex_index,
  input  logic signed [COORD_WIDTH-1:0]       in_coord_x,
  input  logic signed [COORD_WIDTH-1:0]       in_coord_y,
  input  logic signed [COORD_WIDTH-1:0]       in_coord_z,
  input  logic [vnacc_pkg::IDX_W-1:0]         in_index_a,
  input  logic [vnacc_pkg::IDX_W-1:0]         in_index_b,
  input  logic [vnacc_pkg::IDX_W-1:0]         in_index_c,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [vnacc_pkg::OUT_W-1:0]  out_normal_x,
  output logic signed [vnacc_pkg::OUT_W-1:0]  out_normal_y,
  output logic signed [vnacc_pkg::OUT_W-1:0]  out_normal_z,
  output logic [vnacc_pkg::IDX_W-1:0]         out_read_index
);

  localparam int AW    = $clog2(VERTICES);
  localparam int CW    = COORD_WIDTH;
  localparam int EW    = CW + 1;
  localparam int CXW   = 2 * CW + 2;
  localparam int MW    = (2 * CW + 1 > 31) ? 2 * CW + 1 : 31;
  localparam int MULW  = (EW > 31) ? EW : 31;
  localparam int PW    = 2 * MULW;
  localparam int VW    = 3 * CW;
  localparam int SW    = vnacc_pkg::SUM_W;
  localparam int SRW   = 3 * SW;
  localparam int OW    = vnacc_pkg::OUT_W;
  localparam int CNW   = vnacc_pkg::CNT_W;
  localparam int SSW   = vnacc_pkg::SS_W;
  localparam int RTW   = vnacc_pkg::RT_W;
  localparam int QW    = vnacc_pkg::Q_W;
  localparam int NW    = vnacc_pkg::DIV_N_W;
  localparam int NMW   = vnacc_pkg::NM_W;

  vnacc_pkg::state_t state_r, state_nxt;

  logic [AW-1:0]   clr_r;
  logic [2:0]      flip_r;
  logic            op_rd_r;
  logic [AW-1:0]   ia_r, ib_r, ic_r;
  logic [vnacc_pkg::IDX_W-1:0] vi_r;
  logic signed [CW-1:0] va_r [3];
  logic signed [EW-1:0] e1_r [3];
  logic signed [EW-1:0] e2_r [3];
  logic [CNW-1:0]  cnt_r;
  logic signed [PW-1:0]  prod_r;
  logic signed [CXW-1:0] acc_r;
  logic [MW-1:0]   mag_r [3];
  logic [2:0]      neg_r;
  logic [SSW-1:0]  ss_r;
  logic [SSW-1:0]  sv_r;
  logic [SSW:0]    rr_r;
  logic [1:0]      ax_r;
  logic [RTW-1:0]  rem_r;
  logic [QW-1:0]   nlo_r;
  logic [QW-1:0]   q_r;
  logic signed [OW-1:0] res_r [3];

  logic            out_valid_r;
  logic signed [OW-1:0] out_nx_r, out_ny_r, out_nz_r;
  logic [vnacc_pkg::IDX_W-1:0] out_idx_r;

  logic            in_acc;
  logic            out_free;
  logic            vi_in, tri_in;

  logic            v_we;
  logic [AW-1:0]   v_waddr, v_raddr;
  logic [VW-1:0]   v_wdata, v_rdata;
  logic signed [CW-1:0] vd [3];

  logic            s_we;
  logic [AW-1:0]   s_waddr, s_raddr;
  logic [SRW-1:0]  s_wdata, s_rdata;
  logic signed [SW-1:0] sr [3];
  logic signed [SW-1:0] sat [3];
  logic [SW:0]     sabs [3];
  logic signed [SW:0] ssum [3];

  logic [AW-1:0]   corner;
  logic signed [MULW-1:0] mul_a, mul_b;
  logic signed [PW-1:0]   mul_p;
  logic signed [CXW-1:0]  cv;
  logic [CXW-1:0]  cabs;
  logic [1:0]      cax;

  logic            nz_zero, nz_hi, nz_lo;
  logic [SSW:0]    bitv, sq_t;
  logic            sq_ge;
  logic [RTW-1:0]  root;
  logic [NW-1:0]   nn;
  logic [RTW:0]    t_div, d_div;
  logic            d_ge;
  logic [QW-1:0]   q_new, q_cap;
  logic signed [OW-1:0] qs, res_v;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != vnacc_pkg::ST_IDLE);

  assign vi_in  = (int'(in_vertex_index) < VERTICES);
  assign tri_in = (int'(in_index_a) < VERTICES) && (int'(in_index_b) < VERTICES) &&
                  (int'(in_index_c) < VERTICES);

  assign out_valid      = out_valid_r;
  assign out_normal_x   = out_nx_r;
  assign out_normal_y   = out_ny_r;
  assign out_normal_z   = out_nz_r;
  assign out_read_index = out_idx_r;

  vnacc_ram #(.WIDTH(VW), .DEPTH(VERTICES)) u_vert_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (v_wdata),
    .raddr (v_raddr),
    .rdata (v_rdata)
  );

  vnacc_ram #(.WIDTH(SRW), .DEPTH(VERTICES)) u_sum_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  always_comb begin
    vd[0] = v_rdata[VW-1 -: CW];
    vd[1] = v_rdata[2*CW-1 -: CW];
    vd[2] = v_rdata[CW-1:0];
    sr[0] = s_rdata[SRW-1 -: SW];
    sr[1] = s_rdata[2*SW-1 -: SW];
    sr[2] = s_rdata[SW-1:0];
    for (int i = 0; i < 3; i++) begin
      sabs[i] = sr[i][SW-1] ? -(SW+1)'(sr[i]) : (SW+1)'(sr[i]);
      ssum[i] = (SW+1)'(sr[i]) + (SW+1)'(res_r[i]);
      if (ssum[i] > (SW+1)'(vnacc_pkg::SUM_MAX)) begin
        sat[i] = SW'(vnacc_pkg::SUM_MAX);
      end else if (ssum[i] < (SW+1)'(vnacc_pkg::SUM_MIN)) begin
        sat[i] = SW'(vnacc_pkg::SUM_MIN);
      end else begin
        sat[i] = SW'(ssum[i]);
      end
    end
  end

  always_comb begin
    case (cnt_r[1:0])
      2'd0:    corner = ia_r;
      2'd1:    corner = ib_r;
      default: corner = ic_r;
    endcase
  end

  // RAM ports
  always_comb begin
    v_we    = in_acc && (in_op == vnacc_pkg::OP_WRITE) && vi_in;
    v_waddr = AW'(in_vertex_index);
    v_wdata = {in_coord_x, in_coord_y, in_coord_z};
    case (state_r)
      vnacc_pkg::ST_RDA: v_raddr = ia_r;
      vnacc_pkg::ST_RDB: v_raddr = ib_r;
      default:           v_raddr = ic_r;
    endcase
    s_we    = (state_r == vnacc_pkg::ST_CLR) || (state_r == vnacc_pkg::ST_ACCWR);
    s_waddr = (state_r == vnacc_pkg::ST_CLR) ? clr_r : corner;
    s_wdata = (state_r == vnacc_pkg::ST_CLR) ? '0 : {sat[0], sat[1], sat[2]};
    s_raddr = (state_r == vnacc_pkg::ST_SUMRD) ? AW'(vi_r) : corner;
  end

  // Shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == vnacc_pkg::ST_CROSS) begin
      case (cnt_r)
        CNW'(0): begin mul_a = MULW'(e1_r[1]); mul_b = MULW'(e2_r[2]); end
        CNW'(1): begin mul_a = MULW'(e1_r[2]); mul_b = MULW'(e2_r[1]); end
        CNW'(2): begin mul_a = MULW'(e1_r[2]); mul_b = MULW'(e2_r[0]); end
        CNW'(3): begin mul_a = MULW'(e1_r[0]); mul_b = MULW'(e2_r[2]); end
        CNW'(4): begin mul_a = MULW'(e1_r[0]); mul_b = MULW'(e2_r[1]); end
        CNW'(5): begin mul_a = MULW'(e1_r[1]); mul_b = MULW'(e2_r[0]); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else begin
      case (cnt_r[1:0])
        2'd0:    mul_a = MULW'({1'b0, mag_r[0][NMW-1:0]});
        2'd1:    mul_a = MULW'({1'b0, mag_r[1][NMW-1:0]});
        2'd2:    mul_a = MULW'({1'b0, mag_r[2][NMW-1:0]});
        default: mul_a = '0;
      endcase
      mul_b = mul_a;
    end
    mul_p = mul_a * mul_b;
  end

  always_comb begin
    cv   = acc_r - CXW'(prod_r);
    cabs = cv[CXW-1] ? -cv : cv;
    cax  = cnt_r[2:1] - 2'd1;

    nz_zero = (mag_r[0] == '0) && (mag_r[1] == '0) && (mag_r[2] == '0);
    nz_hi   = (|mag_r[0][MW-1:vnacc_pkg::NORM_HI]) || (|mag_r[1][MW-1:vnacc_pkg::NORM_HI]) ||
              (|mag_r[2][MW-1:vnacc_pkg::NORM_HI]);
    nz_lo   = mag_r[0][vnacc_pkg::NORM_LO] || mag_r[1][vnacc_pkg::NORM_LO] ||
              mag_r[2][vnacc_pkg::NORM_LO];

    bitv  = (SSW+1)'(1) << {cnt_r, 1'b0};
    sq_t  = rr_r + bitv;
    sq_ge = ((SSW+1)'(sv_r) >= sq_t);

    root  = rr_r[RTW-1:0];
    nn    = NW'({mag_r[ax_r][NMW-1:0], {vnacc_pkg::FRAC_W{1'b0}}}) + NW'(root >> 1);
    t_div = {rem_r, nlo_r[QW-1]};
    d_div = t_div - {1'b0, root};
    d_ge  = (t_div >= {1'b0, root});
    q_new = {q_r[QW-2:0], d_ge};
    q_cap = (q_new > QW'(vnacc_pkg::ONE_Q14)) ? QW'(vnacc_pkg::ONE_Q14) : q_new;
    qs    = OW'(q_cap);
    res_v = neg_r[ax_r] ? -qs : qs;
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vnacc_pkg::ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      vnacc_pkg::ST_CLR: begin
        if (clr_r == AW'(VERTICES - 1)) begin
          state_nxt = vnacc_pkg::ST_IDLE;
        end
      end
      vnacc_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_op)
            vnacc_pkg::OP_CLEAR: state_nxt = vnacc_pkg::ST_CLR;
            vnacc_pkg::OP_TRI:   state_nxt = tri_in ? vnacc_pkg::ST_RDA : vnacc_pkg::ST_IDLE;
            vnacc_pkg::OP_READ:  state_nxt = vi_in ? vnacc_pkg::ST_SUMRD : vnacc_pkg::ST_OUT;
            default:             state_nxt = vnacc_pkg::ST_IDLE;
          endcase
        end
      end
      vnacc_pkg::ST_RDA:   state_nxt = vnacc_pkg::ST_RDB;
      vnacc_pkg::ST_RDB:   state_nxt = vnacc_pkg::ST_RDC;
      vnacc_pkg::ST_RDC:   state_nxt = vnacc_pkg::ST_RDD;
      vnacc_pkg::ST_RDD:   state_nxt = vnacc_pkg::ST_CROSS;
      vnacc_pkg::ST_CROSS: begin
        if (cnt_r == CNW'(vnacc_pkg::CROSS_LAST)) begin
          state_nxt = vnacc_pkg::ST_NORM;
        end
      end
      vnacc_pkg::ST_SUMRD: state_nxt = vnacc_pkg::ST_SUMLD;
      vnacc_pkg::ST_SUMLD: state_nxt = vnacc_pkg::ST_NORM;
      vnacc_pkg::ST_NORM: begin
        if (nz_zero) begin
          state_nxt = op_rd_r ? vnacc_pkg::ST_OUT : vnacc_pkg::ST_IDLE;
        end else if (!nz_hi && nz_lo) begin
          state_nxt = vnacc_pkg::ST_SQ;
        end
      end
      vnacc_pkg::ST_SQ: begin
        if (cnt_r == CNW'(vnacc_pkg::SQ_LAST)) begin
          state_nxt = vnacc_pkg::ST_SQRT;
        end
      end
      vnacc_pkg::ST_SQRT: begin
        if (cnt_r == '0) begin
          state_nxt = vnacc_pkg::ST_DIVI;
        end
      end
      vnacc_pkg::ST_DIVI:  state_nxt = vnacc_pkg::ST_DIV;
      vnacc_pkg::ST_DIV: begin
        if (cnt_r == '0) begin
          if (ax_r == 2'd2) begin
            state_nxt = op_rd_r ? vnacc_pkg::ST_OUT : vnacc_pkg::ST_ACCRD;
          end else begin
            state_nxt = vnacc_pkg::ST_DIVI;
          end
        end
      end
      vnacc_pkg::ST_ACCRD: state_nxt = vnacc_pkg::ST_ACCWR;
      vnacc_pkg::ST_ACCWR: begin
        state_nxt = (cnt_r == CNW'(2)) ? vnacc_pkg::ST_IDLE : vnacc_pkg::ST_ACCRD;
      end
      vnacc_pkg::ST_OUT: begin
        if (out_free) begin
          state_nxt = vnacc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = vnacc_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r  <= '0;
      flip_r <= '0;
    end else begin
      if (state_r == vnacc_pkg::ST_CLR) begin
        clr_r <= clr_r + AW'(1);
      end else begin
        clr_r <= '0;
      end
      if (cfg_we) begin
        case (cfg_index)
          vnacc_pkg::CFG_FLIP_X: flip_r[0] <= cfg_wdata;
          vnacc_pkg::CFG_FLIP_Y: flip_r[1] <= cfg_wdata;
          vnacc_pkg::CFG_FLIP_Z: flip_r[2] <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state_r)
      vnacc_pkg::ST_IDLE: begin
        op_rd_r <= (in_op == vnacc_pkg::OP_READ);
        ia_r    <= AW'(in_index_a);
        ib_r    <= AW'(in_index_b);
        ic_r    <= AW'(in_index_c);
        vi_r    <= in_vertex_index;
        for (int i = 0; i < 3; i++) begin
          res_r[i] <= '0;
        end
      end
      vnacc_pkg::ST_RDB: begin
        for (int i = 0; i < 3; i++) begin
          va_r[i] <= vd[i];
        end
      end
      vnacc_pkg::ST_RDC: begin
        for (int i = 0; i < 3; i++) begin
          e1_r[i] <= EW'(vd[i]) - EW'(va_r[i]);
        end
      end
      vnacc_pkg::ST_RDD: begin
        for (int i = 0; i < 3; i++) begin
          e2_r[i] <= EW'(vd[i]) - EW'(va_r[i]);
        end
        cnt_r <= '0;
      end
      vnacc_pkg::ST_CROSS: begin
        prod_r <= mul_p;
        cnt_r  <= cnt_r + CNW'(1);
        if (cnt_r[0]) begin
          acc_r <= CXW'(prod_r);
        end else if (cnt_r != '0) begin
          mag_r[cax] <= MW'(cabs);
          neg_r[cax] <= cv[CXW-1];
        end
      end
      vnacc_pkg::ST_SUMLD: begin
        for (int i = 0; i < 3; i++) begin
          mag_r[i] <= MW'(sabs[i]);
          neg_r[i] <= sr[i][SW-1];
        end
      end
      vnacc_pkg::ST_NORM: begin
        cnt_r <= '0;
        if (nz_hi) begin
          for (int i = 0; i < 3; i++) begin
            mag_r[i] <= mag_r[i] >> 1;
          end
        end else if (!nz_lo) begin
          for (int i = 0; i < 3; i++) begin
            mag_r[i] <= mag_r[i] << 1;
          end
        end
      end
      vnacc_pkg::ST_SQ: begin
        prod_r <= mul_p;
        if (cnt_r == CNW'(1)) begin
          ss_r <= SSW'(prod_r);
        end else if (cnt_r != '0) begin
          ss_r <= ss_r + SSW'(prod_r);
        end
        if (cnt_r == CNW'(vnacc_pkg::SQ_LAST)) begin
          sv_r  <= ss_r + SSW'(prod_r);
          rr_r  <= '0;
          cnt_r <= CNW'(vnacc_pkg::SQRT_STEPS - 1);
        end else begin
          cnt_r <= cnt_r + CNW'(1);
        end
      end
      vnacc_pkg::ST_SQRT: begin
        cnt_r <= cnt_r - CNW'(1);
        ax_r  <= '0;
        if (sq_ge) begin
          sv_r <= sv_r - SSW'(sq_t);
          rr_r <= (rr_r >> 1) + bitv;
        end else begin
          rr_r <= rr_r >> 1;
        end
      end
      vnacc_pkg::ST_DIVI: begin
        rem_r <= RTW'(nn[NW-1:QW]);
        nlo_r <= nn[QW-1:0];
        q_r   <= '0;
        cnt_r <= CNW'(vnacc_pkg::DIV_STEPS - 1);
      end
      vnacc_pkg::ST_DIV: begin
        rem_r <= d_ge ? RTW'(d_div) : RTW'(t_div);
        nlo_r <= nlo_r << 1;
        q_r   <= q_new;
        if (cnt_r == '0) begin
          cnt_r       <= '0;
          res_r[ax_r] <= res_v;
          ax_r        <= ax_r + 2'd1;
        end else begin
          cnt_r <= cnt_r - CNW'(1);
        end
      end
      vnacc_pkg::ST_ACCWR: begin
        cnt_r <= cnt_r + CNW'(1);
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == vnacc_pkg::ST_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == vnacc_pkg::ST_OUT && out_free) begin
      out_nx_r  <= flip_r[0] ? -res_r[0] : res_r[0];
      out_ny_r  <= flip_r[1] ? -res_r[1] : res_r[1];
      out_nz_r  <= flip_r[2] ? -res_r[2] : res_r[2];
      out_idx_r <= vi_r;
    end
  end

endmodule

>>> rtl/vnacc_checker.sv
// Port-level checker for the vertex normal accumulator, bound to the top level.
`timescale 1ns / 1ps
`include "vertex_normal_accumulate_core_macros.svh"

module vnacc_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic [1:0]                         in_op,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [vnacc_pkg::OUT_W-1:0] out_normal_x,
  input logic signed [vnacc_pkg::OUT_W-1:0] out_normal_y,
  input logic signed [vnacc_pkg::OUT_W-1:0] out_normal_z,
  input logic [vnacc_pkg::IDX_W-1:0]        out_read_index
);

  `VNACC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_normal_x) && $stable(out_normal_y) && $stable(out_normal_z) && $stable(out_read_index), "stalled result beat changed")

  `VNACC_ASSERT_IMPL(a_out_range, out_valid, out_normal_x >= -16'sd16384 && out_normal_x <= 16'sd16384 && out_normal_y >= -16'sd16384 && out_normal_y <= 16'sd16384 && out_normal_z >= -16'sd16384 && out_normal_z <= 16'sd16384, "normal component outside unit range")

  `VNACC_ASSERT_NEXT(a_busy_after, in_valid && !in_stall && (in_op == vnacc_pkg::OP_READ || in_op == vnacc_pkg::OP_CLEAR), in_stall, "read or clear beat did not hold the input")

  `VNACC_ASSERT_IMPL(a_result_src, $rose(out_valid), $past(in_stall), "result beat appeared without work in progress")

endmodule

bind vertex_normal_accumulate_core vnacc_checker u_vnacc_checker (.*);

>>> bench/testbench.sv
// Self-checking testbench for the vertex normal accumulator core.
`timescale 1ns / 1ps

module testbench;

  localparam int NV         = 1024;
  localparam int IDLE_LIMIT = 6000;
  localparam int DRAIN_WAIT = 300;

  typedef struct {
    logic [1:0]                   op;
    logic [vnacc_pkg::IDX_W-1:0]  vi;
    logic [15:0]                  cx, cy, cz;
    logic [vnacc_pkg::IDX_W-1:0]  a, b, c;
  } mesh_op_t;

  typedef struct {
    logic [vnacc_pkg::OUT_W-1:0]  nx, ny, nz;
    logic [vnacc_pkg::IDX_W-1:0]  idx;
  } normal_t;

  typedef struct {
    int x, y, z;
  } vec_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [vnacc_pkg::CFG_W-1:0] cfg_index;
  logic cfg_wdata;
  logic in_valid;
  logic in_stall;
  logic [1:0] in_op;
  logic [vnacc_pkg::IDX_W-1:0] in_vertex_index;
  logic signed [15:0] in_coord_x, in_coord_y, in_coord_z;
  logic [vnacc_pkg::IDX_W-1:0] in_index_a, in_index_b, in_index_c;
  logic out_valid;
  logic out_stall;
  logic signed [vnacc_pkg::OUT_W-1:0] out_normal_x, out_normal_y, out_normal_z;
  logic [vnacc_pkg::IDX_W-1:0] out_read_index;

  vertex_normal_accumulate_core dut (.*);

  mesh_op_t pending_ops[$];
  normal_t  expected_normals[$];
  mesh_op_t driven_op;
  int errors;

  int pos_x[NV], pos_y[NV], pos_z[NV];
  int acc_x[NV], acc_y[NV], acc_z[NV];
  bit flip_x_m, flip_y_m, flip_z_m;

  bit written[NV];
  int written_list[$];
  int burst_left, gap_left;
  int hold_left, stall_mode, mode_left, results_seen;
  bit long_hold_done;
  int idle_cycles;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, bt;
    r = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt >>= 2;
    while (bt != 0) begin
      if (v >= r + bt) begin
        v -= r + bt;
        r = (r >> 1) + bt;
      end else begin
        r >>= 1;
      end
      bt >>= 2;
    end
    return r;
  endfunction

  function automatic vec_t unit_normal(longint cx, longint cy, longint cz);
    longint c[3];
    longint unsigned m[3], mx, ss, r, q;
    vec_t o;
    int res[3];
    c[0] = cx; c[1] = cy; c[2] = cz;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = c[i] < 0 ? longint'(-c[i]) : longint'(c[i]);
      if (m[i] > mx) mx = m[i];
      res[i] = 0;
    end
    if (mx != 0) begin
      while (mx >= (64'd1 << 30)) begin
        mx >>= 1;
        for (int i = 0; i < 3; i++) m[i] >>= 1;
      end
      while (mx < (64'd1 << 29)) begin
        mx <<= 1;
        for (int i = 0; i < 3; i++) m[i] <<= 1;
      end
      ss = 0;
      for (int i = 0; i < 3; i++) ss += m[i] * m[i];
      r = root_floor(ss);
      for (int i = 0; i < 3; i++) begin
        q = (m[i] * vnacc_pkg::ONE_Q14 + r / 2) / r;
        if (q > vnacc_pkg::ONE_Q14) q = vnacc_pkg::ONE_Q14;
        res[i] = c[i] < 0 ? -int'(q) : int'(q);
      end
    end
    o.x = res[0]; o.y = res[1]; o.z = res[2];
    return o;
  endfunction

  function automatic int sat_sum(int s, int v);
    int t;
    t = s + v;
    if (t > vnacc_pkg::SUM_MAX) return vnacc_pkg::SUM_MAX;
    if (t < vnacc_pkg::SUM_MIN) return vnacc_pkg::SUM_MIN;
    return t;
  endfunction

  function automatic void apply_mesh_op(mesh_op_t m);
    longint e1[3], e2[3];
    int ids[3];
    vec_t n;
    normal_t exp_n;
    case (m.op)
      vnacc_pkg::OP_CLEAR: begin
        for (int i = 0; i < NV; i++) begin
          acc_x[i] = 0; acc_y[i] = 0; acc_z[i] = 0;
        end
      end
      vnacc_pkg::OP_WRITE: begin
        pos_x[m.vi] = int'($signed(m.cx));
        pos_y[m.vi] = int'($signed(m.cy));
        pos_z[m.vi] = int'($signed(m.cz));
      end
      vnacc_pkg::OP_TRI: begin
        ids[0] = m.a; ids[1] = m.b; ids[2] = m.c;
        e1[0] = pos_x[m.b] - pos_x[m.a];
        e1[1] = pos_y[m.b] - pos_y[m.a];
        e1[2] = pos_z[m.b] - pos_z[m.a];
        e2[0] = pos_x[m.c] - pos_x[m.a];
        e2[1] = pos_y[m.c] - pos_y[m.a];
        e2[2] = pos_z[m.c] - pos_z[m.a];
        n = unit_normal(e1[1] * e2[2] - e1[2] * e2[1],
                        e1[2] * e2[0] - e1[0] * e2[2],
                        e1[0] * e2[1] - e1[1] * e2[0]);
        if (n.x != 0 || n.y != 0 || n.z != 0) begin
          for (int i = 0; i < 3; i++) begin
            acc_x[ids[i]] = sat_sum(acc_x[ids[i]], n.x);
            acc_y[ids[i]] = sat_sum(acc_y[ids[i]], n.y);
            acc_z[ids[i]] = sat_sum(acc_z[ids[i]], n.z);
          end
        end
      end
      default: begin
        n = unit_normal(acc_x[m.vi], acc_y[m.vi], acc_z[m.vi]);
        if (flip_x_m) n.x = -n.x;
        if (flip_y_m) n.y = -n.y;
        if (flip_z_m) n.z = -n.z;
        exp_n.nx = n.x[vnacc_pkg::OUT_W-1:0];
        exp_n.ny = n.y[vnacc_pkg::OUT_W-1:0];
        exp_n.nz = n.z[vnacc_pkg::OUT_W-1:0];
        exp_n.idx = m.vi;
        expected_normals = {expected_normals, exp_n};
      end
    endcase
  endfunction

  task automatic queue_op(logic [1:0] op, int vi, int x, int y, int z, int a, int b, int c);
    mesh_op_t m;
    m.op = op; m.vi = vi[vnacc_pkg::IDX_W-1:0];
    m.cx = x[15:0]; m.cy = y[15:0]; m.cz = z[15:0];
    m.a = a[vnacc_pkg::IDX_W-1:0];
    m.b = b[vnacc_pkg::IDX_W-1:0];
    m.c = c[vnacc_pkg::IDX_W-1:0];
    if (op == vnacc_pkg::OP_WRITE && !written[vi]) begin
      written[vi] = 1'b1;
      written_list = {written_list, vi};
    end
    pending_ops = {pending_ops, m};
  endtask

  function automatic int rand_coord();
    case ($urandom_range(0, 9))
      0: return -32768;
      1: return 32767;
      2: return $urandom_range(0, 2000) - 1000;
      default: return int'($signed(16'($urandom)));
    endcase
  endfunction

  task automatic queue_random(int count);
    int pick, vi;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 999);
      vi = $urandom_range(0, 3) == 0 ? $urandom_range(0, NV - 1) : $urandom_range(0, 15);
      if (pick < 7) begin
        queue_op(vnacc_pkg::OP_CLEAR, $urandom_range(0, NV - 1), 0, 0, 0, 0, 0, 0);
      end else if (pick < 260 || written_list.size() < 3) begin
        queue_op(vnacc_pkg::OP_WRITE, vi, rand_coord(), rand_coord(), rand_coord(), 0, 0, 0);
      end else if (pick < 650) begin
        queue_op(vnacc_pkg::OP_TRI, $urandom_range(0, NV - 1), 0, 0, 0,
                 written_list[$urandom_range(0, written_list.size() - 1)],
                 written_list[$urandom_range(0, written_list.size() - 1)],
                 written_list[$urandom_range(0, written_list.size() - 1)]);
      end else begin
        if ($urandom_range(0, 1) == 0)
          vi = written_list[$urandom_range(0, written_list.size() - 1)];
        queue_op(vnacc_pkg::OP_READ, vi, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom);
      end
    end
  endtask

  task automatic drain();
    while (pending_ops.size() != 0 || in_valid || in_stall || expected_normals.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_flips(bit fx, bit fy, bit fz);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= vnacc_pkg::CFG_FLIP_X; cfg_wdata <= fx;
    @(posedge clk);
    cfg_index <= vnacc_pkg::CFG_FLIP_Y; cfg_wdata <= fy;
    @(posedge clk);
    cfg_index <= vnacc_pkg::CFG_FLIP_Z; cfg_wdata <= fz;
    @(posedge clk);
    cfg_we <= 1'b0;
    flip_x_m = fx; flip_y_m = fy; flip_z_m = fz;
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = vnacc_pkg::CFG_FLIP_X; cfg_wdata = 1'b0;
    errors = 0;
    flip_x_m = 0; flip_y_m = 0; flip_z_m = 0;
    for (int i = 0; i < NV; i++) begin
      pos_x[i] = 0; pos_y[i] = 0; pos_z[i] = 0;
      acc_x[i] = 0; acc_y[i] = 0; acc_z[i] = 0;
      written[i] = 1'b0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    set_flips(0, 0, 0);

    queue_op(vnacc_pkg::OP_READ, 5, 0, 0, 0, 0, 0, 0);
    queue_op(vnacc_pkg::OP_WRITE, 0, 0, 0, 0, 0, 0, 0);
    queue_op(vnacc_pkg::OP_WRITE, 1, 32767, 0, 0, 0, 0, 0);
    queue_op(vnacc_pkg::OP_WRITE, 2, 0, 32767, 0, 0, 0, 0);
    queue_op(vnacc_pkg::OP_WRITE, 3, -32768, -32768, -32768, 0, 0, 0);
    queue_op(vnacc_pkg::OP_WRITE, 1023, 32767, 32767, 32767, 0, 0, 0);
    queue_op(vnacc_pkg::OP_WRITE, 4, -32768, 32767, 0, 0, 0, 0);
    queue_op(vnacc_pkg::OP_WRITE, 6, 256, 256, 256, 0, 0, 0);
    queue_op(vnacc_pkg::OP_WRITE, 7, 512, 512, 512, 0, 0, 0);
    queue_op(vnacc_pkg::OP_TRI, 0, 0, 0, 0, 0, 1, 2);
    queue_op(vnacc_pkg::OP_TRI, 0, 0, 0, 0, 0, 0, 1);
    queue_op(vnacc_pkg::OP_TRI, 0, 0, 0, 0, 0, 6, 7);
    queue_op(vnacc_pkg::OP_TRI, 0, 0, 0, 0, 3, 1023, 4);
    queue_op(vnacc_pkg::OP_TRI, 0, 0, 0, 0, 1023, 4, 2);
    queue_op(vnacc_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0);
    queue_op(vnacc_pkg::OP_READ, 1, 0, 0, 0, 0, 0, 0);
    queue_op(vnacc_pkg::OP_READ, 3, 0, 0, 0, 0, 0, 0);
    queue_op(vnacc_pkg::OP_READ, 1023, 0, 0, 0, 0, 0, 0);
    queue_op(vnacc_pkg::OP_READ, 6, 0, 0, 0, 0, 0, 0);
    queue_op(vnacc_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0);
    queue_op(vnacc_pkg::OP_READ, 1023, 0, 0, 0, 0, 0, 0);
    queue_op(vnacc_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0);
    drain();

    set_flips(1, 1, 1);
    queue_op(vnacc_pkg::OP_WRITE, 100, 0, 0, 0, 0, 0, 0);
    queue_op(vnacc_pkg::OP_WRITE, 200, 1000, -300, 50, 0, 0, 0);
    queue_op(vnacc_pkg::OP_WRITE, 300, -200, 900, 700, 0, 0, 0);
    for (int k = 0; k < 530; k++) begin
      queue_op(vnacc_pkg::OP_TRI, 0, 0, 0, 0, 100, 200, 300);
      if (k % 50 == 49) queue_op(vnacc_pkg::OP_READ, 200, 0, 0, 0, 0, 0, 0);
    end
    queue_op(vnacc_pkg::OP_READ, 100, 0, 0, 0, 0, 0, 0);
    queue_random(200);
    drain();

    set_flips(1, 0, 1);
    queue_random(230);
    drain();
    set_flips(0, 1, 0);
    queue_random(230);
    drain();
    set_flips(0, 0, 0);
    queue_random(230);
    drain();

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_op <= vnacc_pkg::OP_CLEAR;
      in_vertex_index <= '0;
      in_coord_x <= '0; in_coord_y <= '0; in_coord_z <= '0;
      in_index_a <= '0; in_index_b <= '0; in_index_c <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) apply_mesh_op(driven_op);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_ops.size() != 0) begin
          driven_op = pending_ops.pop_front();
          in_valid <= 1'b1;
          in_op <= driven_op.op;
          in_vertex_index <= driven_op.vi;
          in_coord_x <= driven_op.cx; in_coord_y <= driven_op.cy; in_coord_z <= driven_op.cz;
          in_index_a <= driven_op.a; in_index_b <= driven_op.b; in_index_c <= driven_op.c;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 30);
            gap_left <= $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 25);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      stall_mode <= 0;
      mode_left <= 0;
      long_hold_done <= 1'b0;
    end else begin
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (!long_hold_done && results_seen >= 40) begin
        long_hold_done <= 1'b1;
        hold_left <= 700;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode <= $urandom_range(0, 2);
          mode_left <= $urandom_range(20, 300);
        end else begin
          mode_left <= mode_left - 1;
        end
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= $urandom_range(0, 1);
          default: out_stall <= $urandom_range(0, 7) < 6;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    normal_t want;
    if (!rst_n) begin
      results_seen <= 0;
    end else if (out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (expected_normals.size() == 0) begin
        $display("%0t: unexpected normal for vertex %0d", $time, out_read_index);
        errors++;
      end else begin
        want = expected_normals.pop_front();
        if (out_normal_x !== want.nx) begin
          $display("%0t: normal_x expected %0d actual %0d", $time,
                   $signed(want.nx), out_normal_x);
          errors++;
        end
        if (out_normal_y !== want.ny) begin
          $display("%0t: normal_y expected %0d actual %0d", $time,
                   $signed(want.ny), out_normal_y);
          errors++;
        end
        if (out_normal_z !== want.nz) begin
          $display("%0t: normal_z expected %0d actual %0d", $time,
                   $signed(want.nz), out_normal_z);
          errors++;
        end
        if (out_read_index !== want.idx) begin
          $display("%0t: read_index expected %0d actual %0d", $time,
                   want.idx, out_read_index);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

>>> files.f
+incdir+rtl
rtl/vnacc_pkg.sv
rtl/vnacc_ram.sv
rtl/vertex_normal_accumulate_core.sv
rtl/vnacc_checker.sv
bench/testbench.sv
